// ----- hw/rtl/oanc_pkg.sv -----
// Shared types, codes and lookup functions for the obstacle avoidance navigation controller.
package oanc_pkg;

	localparam int HIST_DEPTH = 8;
	localparam int PTR_W      = $clog2(HIST_DEPTH);
	localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

	localparam logic [31:0] SCAN_TIMEOUT_MS = 32'd3000;
	localparam logic [9:0]  READING_RST     = 10'd999;
	localparam logic [10:0] SIDE_MARGIN_CM  = 11'd15;
	localparam logic [6:0]  MIN_TURN_SPEED  = 7'd30;
	localparam logic [6:0]  BACKUP_SPEED    = 7'd60;
	localparam logic [6:0]  BLOCKED_SPEED   = 7'd70;

	// Request codes.
	localparam logic [1:0] REQ_STEP  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_STOP  = 2'd2;

	// Motor commands.
	localparam logic [2:0] MOTOR_KEEP  = 3'd0;
	localparam logic [2:0] MOTOR_FWD   = 3'd1;
	localparam logic [2:0] MOTOR_STOP  = 3'd2;
	localparam logic [2:0] MOTOR_REV   = 3'd3;
	localparam logic [2:0] MOTOR_LEFT  = 3'd4;
	localparam logic [2:0] MOTOR_RIGHT = 3'd5;

	// Servo commands.
	localparam logic [1:0] SERVO_KEEP   = 2'd0;
	localparam logic [1:0] SERVO_LEFT   = 2'd1;
	localparam logic [1:0] SERVO_CENTRE = 2'd2;
	localparam logic [1:0] SERVO_RIGHT  = 2'd3;

	// Mode codes as seen on the nav_mode output.
	localparam logic [2:0] MODE_IDLE  = 3'd0;
	localparam logic [2:0] MODE_NAV   = 3'd1;
	localparam logic [2:0] MODE_ALERT = 3'd2;
	localparam logic [2:0] MODE_CRIT  = 3'd3;
	localparam logic [2:0] MODE_SCAN  = 3'd4;
	localparam logic [2:0] MODE_TURN  = 3'd5;
	localparam logic [2:0] MODE_BACK  = 3'd6;
	localparam logic [2:0] MODE_ESC   = 3'd7;

	// Decision codes.
	localparam logic [4:0] DEC_NONE         = 5'd0;
	localparam logic [4:0] DEC_START_DRIVE  = 5'd1;
	localparam logic [4:0] DEC_ALL_FREE     = 5'd2;
	localparam logic [4:0] DEC_ENTER_ALERT  = 5'd3;
	localparam logic [4:0] DEC_OBSTACLE     = 5'd4;
	localparam logic [4:0] DEC_ALERT        = 5'd5;
	localparam logic [4:0] DEC_CRITICAL     = 5'd6;
	localparam logic [4:0] DEC_SCAN_TIMEOUT = 5'd7;
	localparam logic [4:0] DEC_ALL_BLOCKED  = 5'd8;
	localparam logic [4:0] DEC_CENTRE_FREE  = 5'd9;
	localparam logic [4:0] DEC_GO_LEFT      = 5'd10;
	localparam logic [4:0] DEC_GO_RIGHT     = 5'd11;
	localparam logic [4:0] DEC_RIGHT_DEFLT  = 5'd12;
	localparam logic [4:0] DEC_TRAPPED      = 5'd13;
	localparam logic [4:0] DEC_NAV_AFTER    = 5'd14;
	localparam logic [4:0] DEC_RESCAN       = 5'd15;
	localparam logic [4:0] DEC_ESCAPE_DONE  = 5'd16;

	// Configuration register indexes.
	localparam logic [2:0] REG_SPEED_PRESET = 3'd0;
	localparam logic [2:0] REG_SAFE_DIST    = 3'd1;
	localparam logic [2:0] REG_ALERT_DIST   = 3'd2;
	localparam logic [2:0] REG_CRIT_DIST    = 3'd3;
	localparam logic [2:0] REG_BLOCKED_DIST = 3'd4;
	localparam logic [2:0] REG_TURN_TIME    = 3'd5;
	localparam logic [2:0] REG_BACKUP_TIME  = 3'd6;
	localparam logic [2:0] REG_SCAN_SETTLE  = 3'd7;

	// Turn ring slot codes.
	typedef logic [1:0] turn_t;
	localparam turn_t SLOT_LEFT   = 2'd0;
	localparam turn_t SLOT_RIGHT  = 2'd1;
	localparam turn_t SLOT_CENTRE = 2'd2;
	localparam turn_t SLOT_EMPTY  = 2'd3;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_NAV   = 8'b0000_0010,
		ST_ALERT = 8'b0000_0100,
		ST_CRIT  = 8'b0000_1000,
		ST_SCAN  = 8'b0001_0000,
		ST_TURN  = 8'b0010_0000,
		ST_BACK  = 8'b0100_0000,
		ST_ESC   = 8'b1000_0000
	} nav_state_t;

	typedef enum logic [3:0] {
		PH_INIT    = 4'b0001,
		PH_WLEFT   = 4'b0010,
		PH_WCENTRE = 4'b0100,
		PH_WRIGHT  = 4'b1000
	} scan_phase_t;

	typedef struct packed {
		logic [1:0]  speed_preset;
		logic [9:0]  safe_distance_cm;
		logic [9:0]  alert_distance_cm;
		logic [9:0]  critical_distance_cm;
		logic [9:0]  blocked_distance_cm;
		logic [15:0] turn_time_ms;
		logic [15:0] backup_time_ms;
		logic [15:0] scan_settle_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        auto_mode_selected;
		logic [9:0]  distance_cm;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [2:0] motor_cmd;
		logic [6:0] motor_speed_pct;
		logic [1:0] servo_cmd;
		logic [2:0] nav_mode;
		logic [4:0] decision;
		logic [6:0] free_space_pct;
	} result_t;

	typedef struct packed {
		logic  clear;
		logic  record;
		turn_t dir;
	} hist_cmd_t;

	function automatic logic [2:0] mode_code(nav_state_t s);
		logic [2:0] c;
		unique case (s)
			ST_IDLE:  c = MODE_IDLE;
			ST_NAV:   c = MODE_NAV;
			ST_ALERT: c = MODE_ALERT;
			ST_CRIT:  c = MODE_CRIT;
			ST_SCAN:  c = MODE_SCAN;
			ST_TURN:  c = MODE_TURN;
			ST_BACK:  c = MODE_BACK;
			ST_ESC:   c = MODE_ESC;
			default:  c = MODE_IDLE;
		endcase
		return c;
	endfunction

	// Speed by distance zone; the floors of 15 and 10 percent are already folded in.
	function automatic logic [6:0] adaptive_speed(logic [9:0] d, cfg_t cfg);
		logic [6:0] top, s80, s50, s30, sp;
		unique case (cfg.speed_preset)
			2'd2: begin
				top = 7'd50; s80 = 7'd40; s50 = 7'd25; s30 = 7'd15;
			end
			2'd3: begin
				top = 7'd80; s80 = 7'd64; s50 = 7'd40; s30 = 7'd24;
			end
			default: begin
				top = 7'd30; s80 = 7'd24; s50 = 7'd15; s30 = 7'd10;
			end
		endcase
		priority if (d >= cfg.safe_distance_cm) sp = top;
		else if (d >= cfg.alert_distance_cm) sp = s80;
		else if (d >= cfg.critical_distance_cm) sp = s50;
		else sp = s30;
		return sp;
	endfunction

	function automatic logic [6:0] free_space(logic [9:0] d, cfg_t cfg);
		logic [6:0] f;
		priority if (d >= cfg.safe_distance_cm) f = 7'd100;
		else if (d >= cfg.alert_distance_cm) f = 7'd75;
		else if (d >= cfg.critical_distance_cm) f = 7'd50;
		else if (d >= cfg.blocked_distance_cm) f = 7'd25;
		else f = 7'd0;
		return f;
	endfunction

endpackage

// ----- hw/rtl/oanc_cfg.sv -----
// Configuration register file with reset defaults.
module oanc_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	output oanc_pkg::cfg_t   cfg
);

	oanc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_preset         <= 2'd2;
			cfg_q.safe_distance_cm     <= 10'd45;
			cfg_q.alert_distance_cm    <= 10'd30;
			cfg_q.critical_distance_cm <= 10'd15;
			cfg_q.blocked_distance_cm  <= 10'd8;
			cfg_q.turn_time_ms         <= 16'd350;
			cfg_q.backup_time_ms       <= 16'd400;
			cfg_q.scan_settle_ms       <= 16'd120;
		end else if (cfg_we) begin
			unique case (cfg_index)
				oanc_pkg::REG_SPEED_PRESET: cfg_q.speed_preset         <= cfg_data[1:0];
				oanc_pkg::REG_SAFE_DIST:    cfg_q.safe_distance_cm     <= cfg_data[9:0];
				oanc_pkg::REG_ALERT_DIST:   cfg_q.alert_distance_cm    <= cfg_data[9:0];
				oanc_pkg::REG_CRIT_DIST:    cfg_q.critical_distance_cm <= cfg_data[9:0];
				oanc_pkg::REG_BLOCKED_DIST: cfg_q.blocked_distance_cm  <= cfg_data[9:0];
				oanc_pkg::REG_TURN_TIME:    cfg_q.turn_time_ms         <= cfg_data;
				oanc_pkg::REG_BACKUP_TIME:  cfg_q.backup_time_ms       <= cfg_data;
				oanc_pkg::REG_SCAN_SETTLE:  cfg_q.scan_settle_ms       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/oanc_hist.sv -----
// Ring of recent turns with the trapped-vehicle test.
module oanc_hist (
	input  logic                 clk,
	input  logic                 arst_n,
	input  oanc_pkg::hist_cmd_t  cmd,
	output logic                 trapped
);

	oanc_pkg::turn_t                ring_q [oanc_pkg::HIST_DEPTH];
	logic [oanc_pkg::PTR_W-1:0]     ptr_q;
	logic [oanc_pkg::CNT_W-1:0]     n_left;
	logic [oanc_pkg::CNT_W-1:0]     n_right;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < oanc_pkg::HIST_DEPTH; i++) begin
				ring_q[i] <= oanc_pkg::SLOT_EMPTY;
			end
			ptr_q <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < oanc_pkg::HIST_DEPTH; i++) begin
				ring_q[i] <= oanc_pkg::SLOT_EMPTY;
			end
			ptr_q <= '0;
		end else if (cmd.record) begin
			ring_q[ptr_q] <= cmd.dir;
			if (ptr_q == oanc_pkg::PTR_W'(oanc_pkg::HIST_DEPTH - 1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// Only left and right slots count; centre-blocked and empty slots do not.
	always_comb begin
		n_left  = '0;
		n_right = '0;
		for (int i = 0; i < oanc_pkg::HIST_DEPTH; i++) begin
			n_left  = n_left + oanc_pkg::CNT_W'(ring_q[i] == oanc_pkg::SLOT_LEFT);
			n_right = n_right + oanc_pkg::CNT_W'(ring_q[i] == oanc_pkg::SLOT_RIGHT);
		end
	end

	assign trapped = (n_left >= oanc_pkg::CNT_W'(3)) || (n_right >= oanc_pkg::CNT_W'(3));

endmodule

// ----- hw/rtl/oanc_nav.sv -----
// Navigation mode machine: per-tick decision logic and the mode state registers.
module oanc_nav (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  oanc_pkg::cfg_t       cfg,
	input  oanc_pkg::item_t      item,
	input  logic                 trapped,
	output oanc_pkg::hist_cmd_t  hist_cmd,
	output oanc_pkg::result_t    res
);

	oanc_pkg::nav_state_t  state_q, state_d;
	oanc_pkg::scan_phase_t phase_q, phase_d;
	logic                  active_q, active_d;
	logic [31:0]           scan_begin_q, scan_begin_d;
	logic [31:0]           settle_begin_q, settle_begin_d;
	logic [31:0]           action_begin_q, action_begin_d;
	logic [9:0]            left_q, left_d;
	logic [9:0]            centre_q, centre_d;

	logic [2:0]            mc;
	logic [6:0]            sp;
	logic [1:0]            sv;
	logic [4:0]            dec;
	logic [6:0]            v;
	logic [6:0]            v_turn;
	logic [9:0]            d;
	logic [31:0]           now;
	logic [31:0]           scan_el;
	logic [31:0]           settle_el;
	logic [31:0]           action_el;
	logic                  clr;
	logic                  rec;
	oanc_pkg::turn_t       rec_dir;

	assign d         = item.distance_cm;
	assign now       = item.now_ms;
	assign v         = oanc_pkg::adaptive_speed(d, cfg);
	assign v_turn    = (v < oanc_pkg::MIN_TURN_SPEED) ? oanc_pkg::MIN_TURN_SPEED : v;
	assign scan_el   = now - scan_begin_q;
	assign settle_el = now - settle_begin_q;
	assign action_el = now - action_begin_q;

	always_comb begin
		mc             = oanc_pkg::MOTOR_KEEP;
		sp             = '0;
		sv             = oanc_pkg::SERVO_KEEP;
		dec            = oanc_pkg::DEC_NONE;
		state_d        = state_q;
		phase_d        = phase_q;
		active_d       = active_q;
		scan_begin_d   = scan_begin_q;
		settle_begin_d = settle_begin_q;
		action_begin_d = action_begin_q;
		left_d         = left_q;
		centre_d       = centre_q;
		clr            = 1'b0;
		rec            = 1'b0;
		rec_dir        = oanc_pkg::SLOT_EMPTY;

		if (item.req_type == oanc_pkg::REQ_START) begin
			active_d = 1'b1;
			state_d  = oanc_pkg::ST_IDLE;
			clr      = 1'b1;
			mc       = oanc_pkg::MOTOR_STOP;
			sv       = oanc_pkg::SERVO_CENTRE;
		end else if (item.req_type == oanc_pkg::REQ_STOP) begin
			active_d = 1'b0;
			state_d  = oanc_pkg::ST_IDLE;
			mc       = oanc_pkg::MOTOR_STOP;
			sv       = oanc_pkg::SERVO_CENTRE;
		end else if (item.req_type == oanc_pkg::REQ_STEP && item.auto_mode_selected &&
				active_q) begin
			unique case (state_q)
				oanc_pkg::ST_IDLE: begin
					sv      = oanc_pkg::SERVO_CENTRE;
					mc      = oanc_pkg::MOTOR_FWD;
					sp      = v;
					dec     = oanc_pkg::DEC_START_DRIVE;
					state_d = oanc_pkg::ST_NAV;
				end
				oanc_pkg::ST_NAV: begin
					priority if (d > cfg.safe_distance_cm) begin
						mc  = oanc_pkg::MOTOR_FWD;
						sp  = v;
						dec = oanc_pkg::DEC_ALL_FREE;
					end else if (d > cfg.alert_distance_cm) begin
						mc      = oanc_pkg::MOTOR_FWD;
						sp      = v;
						dec     = oanc_pkg::DEC_ENTER_ALERT;
						state_d = oanc_pkg::ST_ALERT;
					end else if (d > cfg.critical_distance_cm) begin
						state_d = oanc_pkg::ST_CRIT;
					end else begin
						mc           = oanc_pkg::MOTOR_STOP;
						dec          = oanc_pkg::DEC_OBSTACLE;
						state_d      = oanc_pkg::ST_SCAN;
						phase_d      = oanc_pkg::PH_INIT;
						scan_begin_d = now;
					end
				end
				oanc_pkg::ST_ALERT: begin
					priority if (d > cfg.alert_distance_cm) begin
						state_d = oanc_pkg::ST_NAV;
					end else if (d <= cfg.critical_distance_cm) begin
						state_d = oanc_pkg::ST_CRIT;
					end else begin
						mc  = oanc_pkg::MOTOR_FWD;
						sp  = v;
						dec = oanc_pkg::DEC_ALERT;
					end
				end
				oanc_pkg::ST_CRIT: begin
					priority if (d > cfg.alert_distance_cm) begin
						state_d = (d > cfg.safe_distance_cm) ? oanc_pkg::ST_NAV
							: oanc_pkg::ST_ALERT;
					end else if (d > cfg.critical_distance_cm) begin
						mc  = oanc_pkg::MOTOR_FWD;
						sp  = v;
						dec = oanc_pkg::DEC_CRITICAL;
					end else begin
						mc           = oanc_pkg::MOTOR_STOP;
						state_d      = oanc_pkg::ST_SCAN;
						phase_d      = oanc_pkg::PH_INIT;
						scan_begin_d = now;
					end
				end
				oanc_pkg::ST_SCAN: begin
					priority if (scan_el > oanc_pkg::SCAN_TIMEOUT_MS) begin
						mc             = oanc_pkg::MOTOR_REV;
						sp             = oanc_pkg::BACKUP_SPEED;
						dec            = oanc_pkg::DEC_SCAN_TIMEOUT;
						state_d        = oanc_pkg::ST_BACK;
						action_begin_d = now;
						phase_d        = oanc_pkg::PH_INIT;
					end else if (phase_q == oanc_pkg::PH_INIT) begin
						mc             = oanc_pkg::MOTOR_STOP;
						sv             = oanc_pkg::SERVO_LEFT;
						settle_begin_d = now;
						phase_d        = oanc_pkg::PH_WLEFT;
					end else if (settle_el < {16'd0, cfg.scan_settle_ms}) begin
						// Servo still settling: hold everything.
					end else if (phase_q == oanc_pkg::PH_WLEFT) begin
						left_d         = d;
						sv             = oanc_pkg::SERVO_CENTRE;
						settle_begin_d = now;
						phase_d        = oanc_pkg::PH_WCENTRE;
					end else if (phase_q == oanc_pkg::PH_WCENTRE) begin
						centre_d       = d;
						sv             = oanc_pkg::SERVO_RIGHT;
						settle_begin_d = now;
						phase_d        = oanc_pkg::PH_WRIGHT;
					end else begin
						sv      = oanc_pkg::SERVO_CENTRE;
						phase_d = oanc_pkg::PH_INIT;
						priority if (left_q < cfg.blocked_distance_cm &&
								centre_q < cfg.blocked_distance_cm &&
								d < cfg.blocked_distance_cm) begin
							mc             = oanc_pkg::MOTOR_REV;
							sp             = oanc_pkg::BLOCKED_SPEED;
							dec            = oanc_pkg::DEC_ALL_BLOCKED;
							state_d        = oanc_pkg::ST_BACK;
							action_begin_d = now;
							rec            = 1'b1;
							rec_dir        = oanc_pkg::SLOT_CENTRE;
						end else if (centre_q >= cfg.critical_distance_cm) begin
							mc      = oanc_pkg::MOTOR_FWD;
							sp      = v;
							dec     = oanc_pkg::DEC_CENTRE_FREE;
							state_d = oanc_pkg::ST_NAV;
						end else if ({1'b0, left_q} > {1'b0, d} + oanc_pkg::SIDE_MARGIN_CM)
								begin
							mc             = oanc_pkg::MOTOR_LEFT;
							sp             = v_turn;
							dec            = oanc_pkg::DEC_GO_LEFT;
							rec            = 1'b1;
							rec_dir        = oanc_pkg::SLOT_LEFT;
							state_d        = oanc_pkg::ST_TURN;
							action_begin_d = now;
						end else begin
							mc             = oanc_pkg::MOTOR_RIGHT;
							sp             = v_turn;
							dec            = ({1'b0, d} > {1'b0, left_q} +
								oanc_pkg::SIDE_MARGIN_CM) ? oanc_pkg::DEC_GO_RIGHT
								: oanc_pkg::DEC_RIGHT_DEFLT;
							rec            = 1'b1;
							rec_dir        = oanc_pkg::SLOT_RIGHT;
							state_d        = oanc_pkg::ST_TURN;
							action_begin_d = now;
						end
					end
				end
				oanc_pkg::ST_TURN: begin
					if (action_el >= {16'd0, cfg.turn_time_ms}) begin
						if (trapped) begin
							mc             = oanc_pkg::MOTOR_STOP;
							dec            = oanc_pkg::DEC_TRAPPED;
							state_d        = oanc_pkg::ST_ESC;
							action_begin_d = now;
						end else begin
							mc      = oanc_pkg::MOTOR_FWD;
							sp      = v;
							dec     = oanc_pkg::DEC_NAV_AFTER;
							state_d = oanc_pkg::ST_NAV;
						end
					end
				end
				oanc_pkg::ST_BACK: begin
					if (action_el >= {16'd0, cfg.backup_time_ms}) begin
						mc           = oanc_pkg::MOTOR_STOP;
						dec          = oanc_pkg::DEC_RESCAN;
						state_d      = oanc_pkg::ST_SCAN;
						phase_d      = oanc_pkg::PH_INIT;
						scan_begin_d = now;
					end
				end
				oanc_pkg::ST_ESC: begin
					if (action_el >= {15'd0, cfg.turn_time_ms, 1'b0}) begin
						mc      = oanc_pkg::MOTOR_FWD;
						sp      = v;
						dec     = oanc_pkg::DEC_ESCAPE_DONE;
						state_d = oanc_pkg::ST_NAV;
						clr     = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= oanc_pkg::ST_IDLE;
			phase_q        <= oanc_pkg::PH_INIT;
			active_q       <= 1'b0;
			scan_begin_q   <= '0;
			settle_begin_q <= '0;
			action_begin_q <= '0;
			left_q         <= oanc_pkg::READING_RST;
			centre_q       <= oanc_pkg::READING_RST;
		end else if (adv) begin
			state_q        <= state_d;
			phase_q        <= phase_d;
			active_q       <= active_d;
			scan_begin_q   <= scan_begin_d;
			settle_begin_q <= settle_begin_d;
			action_begin_q <= action_begin_d;
			left_q         <= left_d;
			centre_q       <= centre_d;
		end
	end

	assign hist_cmd.clear  = adv & clr;
	assign hist_cmd.record = adv & rec;
	assign hist_cmd.dir    = rec_dir;

	assign res.motor_cmd       = mc;
	assign res.motor_speed_pct = sp;
	assign res.servo_cmd       = sv;
	assign res.nav_mode        = oanc_pkg::mode_code(state_d);
	assign res.decision        = dec;
	assign res.free_space_pct  = oanc_pkg::free_space(d, cfg);

endmodule

// ----- hw/rtl/obstacle_avoid_nav_controller.sv -----
// Top level of the obstacle avoidance navigation controller.
//
//   Channel  | Handshake                    | Payload
//   ---------+------------------------------+------------------------------------------
//   in       | in_valid / in_ready          | req_type, auto_mode_selected,
//            |                              | distance_cm, now_ms
//   out      | out_valid / out_ready        | motor_cmd, motor_speed_pct, servo_cmd,
//            |                              | nav_mode, decision, free_space_pct
//   cfg      | cfg_we (no wait)             | cfg_index, cfg_data
//
// A tick is registered on transfer into the input stage; it is then decided and its
// result lands in the output register when the tick moves on from the input stage.
// One tick per cycle is sustained: the input stage empties into the output register
// whenever that register is empty or is being taken in the same cycle.
// The mode state, scan readings and turn ring update exactly when a tick moves from
// the input stage to the output register, so each tick sees the state left by the one
// before it. A stalled output holds both stages; in_ready drops only then.
// Reset (arst_n low) empties both stages and loads the registers and mode state with
// their defaults; no clearing pass follows.
module obstacle_avoid_nav_controller (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic        auto_mode_selected,
	input  logic [9:0]  distance_cm,
	input  logic [31:0] now_ms,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  motor_cmd,
	output logic [6:0]  motor_speed_pct,
	output logic [1:0]  servo_cmd,
	output logic [2:0]  nav_mode,
	output logic [4:0]  decision,
	output logic [6:0]  free_space_pct,

	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	oanc_pkg::cfg_t      cfg;
	oanc_pkg::item_t     item_s1;
	logic                valid_s1;
	oanc_pkg::result_t   res;
	oanc_pkg::result_t   res_s2;
	logic                valid_s2;
	oanc_pkg::hist_cmd_t hist_cmd;
	logic                trapped;
	logic                adv;

	// The tick in the input stage moves on when the output register is free or is
	// being taken by the consumer in this same cycle.
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input payload: loaded on every transfer; no reset needed.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.req_type           <= req_type;
			item_s1.auto_mode_selected <= auto_mode_selected;
			item_s1.distance_cm        <= distance_cm;
			item_s1.now_ms             <= now_ms;
		end
	end

	oanc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	oanc_hist u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (hist_cmd),
		.trapped (trapped)
	);

	oanc_nav u_nav (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.cfg      (cfg),
		.item     (item_s1),
		.trapped  (trapped),
		.hist_cmd (hist_cmd),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign motor_cmd       = res_s2.motor_cmd;
	assign motor_speed_pct = res_s2.motor_speed_pct;
	assign servo_cmd       = res_s2.servo_cmd;
	assign nav_mode        = res_s2.nav_mode;
	assign decision        = res_s2.decision;
	assign free_space_pct  = res_s2.free_space_pct;

endmodule

// ----- tb/tb_obstacle_avoid_nav_controller.sv -----
// Self-checking testbench for the obstacle avoidance navigation controller.
`timescale 1ns / 100ps

import oanc_pkg::*;

// Scoreboard: keeps its own copy of the controller state and registers, works out the
// result of every tick at the moment the tick is accepted, and checks returned results
// in order against what it worked out.
class nav_result_board;
	cfg_t        cfg;
	bit          active;
	logic [2:0]  mode;
	scan_phase_t phase;
	bit [31:0]   scan_begin;
	bit [31:0]   settle_begin;
	bit [31:0]   action_begin;
	int          left_cm;
	int          centre_cm;
	turn_t       turns[HIST_DEPTH];
	int          turn_ptr;
	result_t     pending_results[$];
	int          mismatches;

	function new();
		cfg = '{speed_preset: 2'd2, safe_distance_cm: 10'd45, alert_distance_cm: 10'd30,
			critical_distance_cm: 10'd15, blocked_distance_cm: 10'd8,
			turn_time_ms: 16'd350, backup_time_ms: 16'd400, scan_settle_ms: 16'd120};
		active = 1'b0;
		mode = MODE_IDLE;
		phase = PH_INIT;
		scan_begin = '0;
		settle_begin = '0;
		action_begin = '0;
		left_cm = READING_RST;
		centre_cm = READING_RST;
		clear_turns();
		mismatches = 0;
	endfunction

	function void apply_reg(logic [2:0] idx, logic [15:0] val);
		case (idx)
			REG_SPEED_PRESET: cfg.speed_preset = val[1:0];
			REG_SAFE_DIST:    cfg.safe_distance_cm = val[9:0];
			REG_ALERT_DIST:   cfg.alert_distance_cm = val[9:0];
			REG_CRIT_DIST:    cfg.critical_distance_cm = val[9:0];
			REG_BLOCKED_DIST: cfg.blocked_distance_cm = val[9:0];
			REG_TURN_TIME:    cfg.turn_time_ms = val;
			REG_BACKUP_TIME:  cfg.backup_time_ms = val;
			default:          cfg.scan_settle_ms = val;
		endcase
	endfunction

	function void clear_turns();
		foreach (turns[i]) turns[i] = SLOT_EMPTY;
		turn_ptr = 0;
	endfunction

	function void log_turn(turn_t dir);
		turns[turn_ptr] = dir;
		turn_ptr = (turn_ptr + 1) % HIST_DEPTH;
	endfunction

	// Only left and right slots count; empty and centre-blocked slots are ignored.
	function bit boxed_in();
		int lefts;
		int rights;
		lefts = 0;
		rights = 0;
		foreach (turns[i]) begin
			if (turns[i] == SLOT_LEFT) lefts++;
			else if (turns[i] == SLOT_RIGHT) rights++;
		end
		return lefts >= 3 || rights >= 3;
	endfunction

	// A preset of zero behaves like the slowest preset.
	function int zone_speed(int d);
		int top;
		case (cfg.speed_preset)
			2'd2:    top = 50;
			2'd3:    top = 80;
			default: top = 30;
		endcase
		if (d >= cfg.safe_distance_cm) return top;
		if (d >= cfg.alert_distance_cm) return (top * 80 / 100 > 15) ? top * 80 / 100 : 15;
		if (d >= cfg.critical_distance_cm) return (top * 50 / 100 > 15) ? top * 50 / 100 : 15;
		return (top * 30 / 100 > 10) ? top * 30 / 100 : 10;
	endfunction

	function int free_pct(int d);
		if (d >= cfg.safe_distance_cm) return 100;
		if (d >= cfg.alert_distance_cm) return 75;
		if (d >= cfg.critical_distance_cm) return 50;
		if (d >= cfg.blocked_distance_cm) return 25;
		return 0;
	endfunction

	function void enter_scan(bit [31:0] now);
		mode = MODE_SCAN;
		phase = PH_INIT;
		scan_begin = now;
	endfunction

	function void predict_tick(item_t t);
		result_t   e;
		int        d;
		int        v;
		int        turn_v;
		int        l;
		int        c;
		int        rr;
		bit [31:0] now;
		bit [31:0] escape_ms;
		d = t.distance_cm;
		now = t.now_ms;
		v = zone_speed(d);
		turn_v = (v > MIN_TURN_SPEED) ? v : MIN_TURN_SPEED;
		escape_ms = {15'd0, cfg.turn_time_ms, 1'b0};
		e = '0;
		e.motor_cmd = MOTOR_KEEP;
		e.servo_cmd = SERVO_KEEP;
		e.decision = DEC_NONE;
		if (t.req_type == REQ_START) begin
			// Start ignores the mode selector and empties the turn ring.
			active = 1'b1;
			mode = MODE_IDLE;
			clear_turns();
			e.motor_cmd = MOTOR_STOP;
			e.servo_cmd = SERVO_CENTRE;
		end else if (t.req_type == REQ_STOP) begin
			active = 1'b0;
			mode = MODE_IDLE;
			e.motor_cmd = MOTOR_STOP;
			e.servo_cmd = SERVO_CENTRE;
		end else if (t.req_type == REQ_STEP && t.auto_mode_selected && active) begin
			case (mode)
				MODE_IDLE: begin
					e.servo_cmd = SERVO_CENTRE;
					e.motor_cmd = MOTOR_FWD;
					e.motor_speed_pct = 7'(v);
					e.decision = DEC_START_DRIVE;
					mode = MODE_NAV;
				end
				MODE_NAV: begin
					if (d > cfg.safe_distance_cm) begin
						e.motor_cmd = MOTOR_FWD;
						e.motor_speed_pct = 7'(v);
						e.decision = DEC_ALL_FREE;
					end else if (d > cfg.alert_distance_cm) begin
						e.motor_cmd = MOTOR_FWD;
						e.motor_speed_pct = 7'(v);
						e.decision = DEC_ENTER_ALERT;
						mode = MODE_ALERT;
					end else if (d > cfg.critical_distance_cm) begin
						mode = MODE_CRIT;
					end else begin
						e.motor_cmd = MOTOR_STOP;
						e.decision = DEC_OBSTACLE;
						enter_scan(now);
					end
				end
				MODE_ALERT: begin
					if (d > cfg.alert_distance_cm) mode = MODE_NAV;
					else if (d <= cfg.critical_distance_cm) mode = MODE_CRIT;
					else begin
						e.motor_cmd = MOTOR_FWD;
						e.motor_speed_pct = 7'(v);
						e.decision = DEC_ALERT;
					end
				end
				MODE_CRIT: begin
					if (d > cfg.alert_distance_cm) begin
						mode = (d > cfg.safe_distance_cm) ? MODE_NAV : MODE_ALERT;
					end else if (d > cfg.critical_distance_cm) begin
						e.motor_cmd = MOTOR_FWD;
						e.motor_speed_pct = 7'(v);
						e.decision = DEC_CRITICAL;
					end else begin
						e.motor_cmd = MOTOR_STOP;
						enter_scan(now);
					end
				end
				MODE_SCAN: begin
					if (now - scan_begin > SCAN_TIMEOUT_MS) begin
						e.motor_cmd = MOTOR_REV;
						e.motor_speed_pct = BACKUP_SPEED;
						e.decision = DEC_SCAN_TIMEOUT;
						mode = MODE_BACK;
						action_begin = now;
						phase = PH_INIT;
					end else if (phase == PH_INIT) begin
						e.motor_cmd = MOTOR_STOP;
						e.servo_cmd = SERVO_LEFT;
						settle_begin = now;
						phase = PH_WLEFT;
					end else if (now - settle_begin < cfg.scan_settle_ms) begin
						// The servo is still settling.
					end else if (phase == PH_WLEFT) begin
						left_cm = d;
						e.servo_cmd = SERVO_CENTRE;
						settle_begin = now;
						phase = PH_WCENTRE;
					end else if (phase == PH_WCENTRE) begin
						centre_cm = d;
						e.servo_cmd = SERVO_RIGHT;
						settle_begin = now;
						phase = PH_WRIGHT;
					end else begin
						l = left_cm;
						c = centre_cm;
						rr = d;
						e.servo_cmd = SERVO_CENTRE;
						if (l < cfg.blocked_distance_cm && c < cfg.blocked_distance_cm &&
							rr < cfg.blocked_distance_cm) begin
							e.motor_cmd = MOTOR_REV;
							e.motor_speed_pct = BLOCKED_SPEED;
							e.decision = DEC_ALL_BLOCKED;
							mode = MODE_BACK;
							action_begin = now;
							log_turn(SLOT_CENTRE);
						end else if (c >= cfg.critical_distance_cm) begin
							e.motor_cmd = MOTOR_FWD;
							e.motor_speed_pct = 7'(v);
							e.decision = DEC_CENTRE_FREE;
							mode = MODE_NAV;
						end else if (l > rr + SIDE_MARGIN_CM) begin
							e.motor_cmd = MOTOR_LEFT;
							e.motor_speed_pct = 7'(turn_v);
							e.decision = DEC_GO_LEFT;
							log_turn(SLOT_LEFT);
							mode = MODE_TURN;
							action_begin = now;
						end else begin
							e.motor_cmd = MOTOR_RIGHT;
							e.motor_speed_pct = 7'(turn_v);
							e.decision = (rr > l + SIDE_MARGIN_CM) ? DEC_GO_RIGHT
								: DEC_RIGHT_DEFLT;
							log_turn(SLOT_RIGHT);
							mode = MODE_TURN;
							action_begin = now;
						end
						phase = PH_INIT;
					end
				end
				MODE_TURN: begin
					if (now - action_begin >= cfg.turn_time_ms) begin
						if (boxed_in()) begin
							e.motor_cmd = MOTOR_STOP;
							e.decision = DEC_TRAPPED;
							mode = MODE_ESC;
							action_begin = now;
						end else begin
							e.motor_cmd = MOTOR_FWD;
							e.motor_speed_pct = 7'(v);
							e.decision = DEC_NAV_AFTER;
							mode = MODE_NAV;
						end
					end
				end
				MODE_BACK: begin
					if (now - action_begin >= cfg.backup_time_ms) begin
						e.motor_cmd = MOTOR_STOP;
						e.decision = DEC_RESCAN;
						enter_scan(now);
					end
				end
				default: begin
					// Escape keeps the motors stopped until twice the turn time has passed.
					if (now - action_begin >= escape_ms) begin
						e.motor_cmd = MOTOR_FWD;
						e.motor_speed_pct = 7'(v);
						e.decision = DEC_ESCAPE_DONE;
						mode = MODE_NAV;
						clear_turns();
					end
				end
			endcase
		end
		e.nav_mode = mode;
		e.free_space_pct = 7'(free_pct(d));
		pending_results.push_back(e);
	endfunction

	function void compare_field(string name, logic [6:0] want, logic [6:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			mismatches++;
		end
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			$error("result with no tick outstanding: %h", got);
			mismatches++;
			return;
		end
		want = pending_results.pop_front();
		compare_field("motor_cmd", 7'(want.motor_cmd), 7'(got.motor_cmd));
		compare_field("motor_speed_pct", want.motor_speed_pct, got.motor_speed_pct);
		compare_field("servo_cmd", 7'(want.servo_cmd), 7'(got.servo_cmd));
		compare_field("nav_mode", 7'(want.nav_mode), 7'(got.nav_mode));
		compare_field("decision", 7'(want.decision), 7'(got.decision));
		compare_field("free_space_pct", want.free_space_pct, got.free_space_pct);
	endfunction
endclass

module tb_obstacle_avoid_nav_controller;

	// Request code 3 is not defined; the controller must treat it as an inactive step.
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	localparam int TICKS_PER_PHASE = 195;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int HOLD_OFF_TICKS  = 60;

	// Register settings, one per phase of the random part, in this order.
	typedef enum int {
		CFG_DEFAULTS_SLOW,
		CFG_FAST_ORDERED,
		CFG_ALL_ZERO,
		CFG_ALL_MAX,
		CFG_SCRAMBLED,
		CFG_TIGHT,
		CFG_COUNT
	} cfg_kind_e;

	// How the receiver paces out_ready over one stretch of cycles.
	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_SLOW,
		RX_PERIODIC
	} rx_style_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = REQ_STEP;
	logic        auto_mode_selected = 1'b0;
	logic [9:0]  distance_cm = '0;
	logic [31:0] now_ms = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  motor_cmd;
	logic [6:0]  motor_speed_pct;
	logic [1:0]  servo_cmd;
	logic [2:0]  nav_mode;
	logic [4:0]  decision;
	logic [6:0]  free_space_pct;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_SPEED_PRESET;
	logic [15:0] cfg_data = '0;

	nav_result_board sb = new();

	// Timestamp of the last tick sent; the random part advances it from here.
	bit [31:0] clock_ms;
	// Number of long hold-offs the stimulus has asked the receiver for so far.
	int        hold_off_reqs = 0;

	obstacle_avoid_nav_controller dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.req_type           (req_type),
		.auto_mode_selected (auto_mode_selected),
		.distance_cm        (distance_cm),
		.now_ms             (now_ms),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.motor_cmd          (motor_cmd),
		.motor_speed_pct    (motor_speed_pct),
		.servo_cmd          (servo_cmd),
		.nav_mode           (nav_mode),
		.decision           (decision),
		.free_space_pct     (free_space_pct),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	always #6 clk = ~clk;

	// Hard limit on the run. A correct run needs well under a tenth of this.
	initial begin
		#6_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic item_t make_tick(logic [1:0] req, logic sel, int d, bit [31:0] now);
		item_t t;
		t.req_type = req;
		t.auto_mode_selected = sel;
		t.distance_cm = 10'(d);
		t.now_ms = now;
		return t;
	endfunction

	// Distances cluster around the thresholds currently loaded, with some spread over
	// the lower range and some over the whole field.
	function automatic int pick_distance();
		int r;
		int th;
		int d;
		int span;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			case ($urandom_range(0, 3))
				0:       th = sb.cfg.safe_distance_cm;
				1:       th = sb.cfg.alert_distance_cm;
				2:       th = sb.cfg.critical_distance_cm;
				default: th = sb.cfg.blocked_distance_cm;
			endcase
			d = th + $urandom_range(0, 2) - 1;
			if (d < 0) d = 0;
			if (d > 1023) d = 1023;
			return d;
		end
		if (r < 80) begin
			span = 2 * sb.cfg.safe_distance_cm + 10;
			if (span > 1023) span = 1023;
			return $urandom_range(0, span);
		end
		return $urandom_range(0, 1023);
	endfunction

	// Times in a timed mode land mostly on the deadline, one either side of it or on
	// it, so that both outcomes of every time comparison occur.
	function automatic bit [31:0] near_deadline(bit [31:0] start, bit [31:0] dur);
		if ($urandom_range(0, 9) < 6) return start + dur - 1 + $urandom_range(0, 2);
		return clock_ms + $urandom_range(0, dur / 4 + 1);
	endfunction

	// Mostly well-formed active steps whose timing follows the mode the controller is
	// in; the rest are starts, stops, undefined requests and deselected steps.
	function automatic item_t next_tick();
		item_t     t;
		int        r;
		bit [31:0] now;
		r = $urandom_range(0, 99);
		t = make_tick(REQ_STEP, 1'b1, pick_distance(), '0);
		if (!sb.active && r < 60) t.req_type = REQ_START;
		else if (r < 2) t.req_type = REQ_START;
		else if (r < 4) t.req_type = REQ_STOP;
		else if (r < 6) t.req_type = REQ_UNKNOWN;
		else if (r < 10) t.auto_mode_selected = 1'b0;
		case (sb.mode)
			MODE_SCAN: begin
				if ($urandom_range(0, 9) == 0)
					now = sb.scan_begin + SCAN_TIMEOUT_MS + $urandom_range(0, 1);
				else
					now = near_deadline(sb.settle_begin, 32'(sb.cfg.scan_settle_ms));
			end
			MODE_TURN: now = near_deadline(sb.action_begin, 32'(sb.cfg.turn_time_ms));
			MODE_BACK: now = near_deadline(sb.action_begin, 32'(sb.cfg.backup_time_ms));
			MODE_ESC:  now = near_deadline(sb.action_begin, 32'(sb.cfg.turn_time_ms) * 2);
			default:   now = clock_ms + $urandom_range(0, 100);
		endcase
		// Rare jumps anywhere on the clock, which also wrap it.
		if ($urandom_range(0, 49) == 0) now = $urandom();
		t.now_ms = now;
		clock_ms = now;
		return t;
	endfunction

	function automatic cfg_t phase_cfg(cfg_kind_e kind);
		cfg_t c;
		int   step_a;
		case (kind)
			CFG_DEFAULTS_SLOW: begin
				c = '{2'd1, 10'd45, 10'd30, 10'd15, 10'd8, 16'd350, 16'd400, 16'd120};
			end
			CFG_FAST_ORDERED: begin
				c.speed_preset = 2'd3;
				c.blocked_distance_cm = 10'($urandom_range(0, 40));
				c.critical_distance_cm = c.blocked_distance_cm + 10'($urandom_range(0, 40));
				c.alert_distance_cm = c.critical_distance_cm + 10'($urandom_range(0, 40));
				c.safe_distance_cm = c.alert_distance_cm + 10'($urandom_range(0, 40));
				c.turn_time_ms = 16'($urandom_range(0, 600));
				c.backup_time_ms = 16'($urandom_range(0, 600));
				c.scan_settle_ms = 16'($urandom_range(0, 600));
			end
			CFG_ALL_ZERO: begin
				// Preset zero acts as the slowest preset.
				c = '0;
			end
			CFG_ALL_MAX: begin
				c = '{2'd3, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF,
					16'hFFFF};
			end
			CFG_SCRAMBLED: begin
				c.speed_preset = 2'($urandom_range(0, 3));
				c.safe_distance_cm = 10'($urandom_range(0, 1023));
				c.alert_distance_cm = 10'($urandom_range(0, 1023));
				c.critical_distance_cm = 10'($urandom_range(0, 1023));
				c.blocked_distance_cm = 10'($urandom_range(0, 1023));
				c.turn_time_ms = 16'($urandom());
				c.backup_time_ms = 16'($urandom());
				c.scan_settle_ms = 16'($urandom());
			end
			default: begin
				step_a = $urandom_range(1, 8);
				c.speed_preset = 2'd2;
				c.blocked_distance_cm = 10'(step_a);
				c.critical_distance_cm = 10'(2 * step_a);
				c.alert_distance_cm = 10'(3 * step_a);
				c.safe_distance_cm = 10'(4 * step_a);
				c.turn_time_ms = 16'($urandom_range(0, 200));
				c.backup_time_ms = 16'($urandom_range(0, 200));
				c.scan_settle_ms = 16'($urandom_range(0, 200));
			end
		endcase
		return c;
	endfunction

	// One register write per clock edge; the write enable stays high across a run of
	// writes and is lowered by the caller.
	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.apply_reg(idx, val);
	endtask

	task automatic set_config(cfg_t c);
		write_reg(REG_SPEED_PRESET, 16'(c.speed_preset));
		write_reg(REG_SAFE_DIST, 16'(c.safe_distance_cm));
		write_reg(REG_ALERT_DIST, 16'(c.alert_distance_cm));
		write_reg(REG_CRIT_DIST, 16'(c.critical_distance_cm));
		write_reg(REG_BLOCKED_DIST, 16'(c.blocked_distance_cm));
		write_reg(REG_TURN_TIME, c.turn_time_ms);
		write_reg(REG_BACKUP_TIME, c.backup_time_ms);
		write_reg(REG_SCAN_SETTLE, c.scan_settle_ms);
		cfg_we <= 1'b0;
	endtask

	// Offers one tick and returns at the edge where it transfers. Valid is left high so
	// a following tick can be offered in the same step without a bubble.
	task automatic send_tick(item_t t);
		req_type <= t.req_type;
		auto_mode_selected <= t.auto_mode_selected;
		distance_cm <= t.distance_cm;
		now_ms <= t.now_ms;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.predict_tick(t);
	endtask

	task automatic idle_gap(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stops offering ticks and waits until every outstanding result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Receiver: checks every result that transfers, then picks out_ready for the next
	// edge. The pacing style changes every stretch of cycles; a hold-off request from
	// the stimulus forces out_ready low for a long, counted stretch.
	initial begin : receiver
		int        seg_left;
		int        hold_left;
		int        hold_off_seen;
		rx_style_e style;
		bit        nxt;
		seg_left = 0;
		hold_left = 0;
		hold_off_seen = 0;
		style = RX_FREE;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result(result_t'({motor_cmd, motor_speed_pct, servo_cmd, nav_mode,
					decision, free_space_pct}));
			if (hold_off_reqs != hold_off_seen) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_off_seen = hold_off_reqs;
			end
			if (seg_left == 0) begin
				style = rx_style_e'($urandom_range(0, 3));
				seg_left = $urandom_range(20, 200);
			end
			seg_left--;
			if (hold_left > 0) begin
				hold_left--;
				nxt = 1'b0;
			end else begin
				case (style)
					RX_FREE:  nxt = 1'b1;
					RX_COIN:  nxt = 1'($urandom_range(0, 1));
					RX_SLOW:  nxt = ($urandom_range(0, 4) == 0);
					default:  nxt = (seg_left % 4) != 0;
				endcase
			end
			out_ready <= nxt;
		end
	end

	initial begin : stimulus
		int burst_left;
		int gap;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks under the reset register values. They walk through inactive
		// steps, an undefined request, a start that ignores the mode selector, every
		// driving mode and its exits, a scan that finds all three directions blocked,
		// reversing into a rescan, the scan timeout on both sides of its limit, and a
		// stop. Distances and timestamps include the ends of their ranges.
		send_tick(make_tick(REQ_STEP, 1'b1, 0, 32'd0));
		send_tick(make_tick(REQ_UNKNOWN, 1'b1, 1023, 32'hFFFF_FFFF));
		send_tick(make_tick(REQ_START, 1'b0, 45, 32'd1000));
		send_tick(make_tick(REQ_STEP, 1'b0, 45, 32'd1010));
		send_tick(make_tick(REQ_STEP, 1'b1, 1023, 32'd1020));
		send_tick(make_tick(REQ_STEP, 1'b1, 46, 32'd1030));
		send_tick(make_tick(REQ_STEP, 1'b1, 45, 32'd1040));
		send_tick(make_tick(REQ_STEP, 1'b1, 30, 32'd1050));
		send_tick(make_tick(REQ_STEP, 1'b1, 15, 32'd1060));
		send_tick(make_tick(REQ_STEP, 1'b1, 16, 32'd1070));
		send_tick(make_tick(REQ_STEP, 1'b1, 31, 32'd1080));
		send_tick(make_tick(REQ_STEP, 1'b1, 31, 32'd1090));
		send_tick(make_tick(REQ_STEP, 1'b1, 20, 32'd1100));
		send_tick(make_tick(REQ_STEP, 1'b1, 46, 32'd1110));
		send_tick(make_tick(REQ_STEP, 1'b1, 15, 32'd2000));
		send_tick(make_tick(REQ_STEP, 1'b1, 3, 32'd2000));
		send_tick(make_tick(REQ_STEP, 1'b1, 3, 32'd2119));
		send_tick(make_tick(REQ_STEP, 1'b1, 3, 32'd2120));
		send_tick(make_tick(REQ_STEP, 1'b1, 7, 32'd2240));
		send_tick(make_tick(REQ_STEP, 1'b1, 0, 32'd2360));
		send_tick(make_tick(REQ_STEP, 1'b1, 50, 32'd2759));
		send_tick(make_tick(REQ_STEP, 1'b1, 50, 32'd2760));
		send_tick(make_tick(REQ_STEP, 1'b1, 50, 32'd5760));
		send_tick(make_tick(REQ_STEP, 1'b1, 50, 32'd5761));
		send_tick(make_tick(REQ_STOP, 1'b1, 8, 32'd5800));
		drain();

		// Random part: one register setting per phase, each loaded while the controller
		// is empty. The sender works in bursts with random gaps, sometimes in long runs
		// with no gaps at all.
		clock_ms = $urandom();
		for (int p = 0; p < CFG_COUNT; p++) begin
			set_config(phase_cfg(cfg_kind_e'(p)));
			burst_left = 0;
			for (int i = 0; i < TICKS_PER_PHASE; i++) begin
				// Long receiver hold-off while ticks keep coming, so the pipeline fills
				// and in_ready drops.
				if (p == CFG_FAST_ORDERED && i == 80) begin
					hold_off_reqs++;
					burst_left = HOLD_OFF_TICKS;
				end
				// Once in mid-phase the sender waits for every result to come back.
				if (p == CFG_ALL_MAX && i == 100) begin
					drain();
					burst_left = 0;
				end
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					if ($urandom_range(0, 9) == 0) begin
						burst_left = 150;
						gap = 0;
					end
					if (gap > 0) idle_gap(gap);
				end
				burst_left--;
				send_tick(next_tick());
			end
			drain();
		end

		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
